// File: hdl/cpfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_pkg - shared definitions for the capture pair frequency meter
// Job format between front end and divider, register map and reset values.
// ----------------------------------------------------------------------------
package cpfm_pkg;

    // field widths
    localparam int CAP_W    = 16;
    localparam int FREQ_W   = 32;
    localparam int SLOT_W   = 5;
    localparam int LOGGED_W = 22;

    // log and queue sizing
    localparam int LOG_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;

    // arithmetic constants
    localparam logic [CAP_W:0] WRAP_TOP  = 17'h0FFFF;
    localparam int             LOG_SHIFT = 5;  // times 33 is (p << 5) + p

    // configuration port
    localparam int              APB_ADDR_W        = 3;
    localparam int              APB_DATA_W        = 32;
    localparam logic            REG_TIMER_CLOCK   = 1'b0;
    localparam logic [FREQ_W-1:0] TIMER_CLOCK_RST = 32'd100000000;

    // one measured period waiting for its division
    typedef struct packed {
        logic [CAP_W-1:0]    period;
        logic                zero;
        logic                written;
        logic [SLOT_W-1:0]   slot;
        logic [LOGGED_W-1:0] logged;
    } job_t;

endpackage

// File: hdl/cpfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_if - valid/ready channels of the capture pair frequency meter
// Capture event channel and measurement result channel.
// ----------------------------------------------------------------------------
interface cpfm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        on_measured_channel;
    logic [cpfm_pkg::CAP_W-1:0]  capture_value;

    modport source (output valid, on_measured_channel, capture_value, input ready);
    modport sink   (input valid, on_measured_channel, capture_value, output ready);
endinterface

interface cpfm_out_if;
    logic                           valid;
    logic                           ready;
    logic [cpfm_pkg::CAP_W-1:0]     period_ticks;
    logic [cpfm_pkg::FREQ_W-1:0]    frequency_hz;
    logic                           zero_period;
    logic                           log_written;
    logic [cpfm_pkg::SLOT_W-1:0]    log_slot;
    logic [cpfm_pkg::LOGGED_W-1:0]  logged_value;

    modport source (output valid, period_ticks, frequency_hz, zero_period, log_written,
                    log_slot, logged_value, input ready);
    modport sink   (input valid, period_ticks, frequency_hz, zero_period, log_written,
                    log_slot, logged_value, output ready);
endinterface

// File: hdl/capture_pair_frequency_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_pair_frequency_meter - frequency meter from pairs of capture values
// Pairs measured captures, logs the scaled period, divides the timer clock
// by the period and returns one result transaction per pair.
// ----------------------------------------------------------------------------
// capture transactions are taken while the job queue has room
// a pair's job passes the queue, the 32 step divider and the output register
// a zero period skips the division steps on its way to the output register
// sustained rate is bounded by the divider, which takes one job at a time
// first captures and other-channel captures give no result
// reset clears pairing state, log fill count and queue, resets the timer clock
// register to its default; the period log contents are not cleared
module capture_pair_frequency_meter #(
    parameter int LOG_DEPTH = cpfm_pkg::LOG_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cpfm_in_if.sink                         capture,
    cpfm_out_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpfm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cpfm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cpfm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [cpfm_pkg::FREQ_W-1:0] timer_clock_reg;
    logic                        reg_hit;
    logic                        push;
    logic                        full;
    logic                        pop;
    logic                        avail;
    cpfm_pkg::job_t              push_job;
    cpfm_pkg::job_t              pop_job;

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[cpfm_pkg::APB_ADDR_W-1] == cpfm_pkg::REG_TIMER_CLOCK);
    assign prdata  = reg_hit ? timer_clock_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= cpfm_pkg::TIMER_CLOCK_RST;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            timer_clock_reg <= pwdata;
        end
    end

    // capture pairing and logging
    cpfm_front #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .capture  (capture),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    // job queue
    cpfm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .pop_job  (pop_job)
    );

    // frequency division and result register
    cpfm_divider u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .avail          (avail),
        .pop_job        (pop_job),
        .pop            (pop),
        .timer_clock_hz (timer_clock_reg),
        .result         (result)
    );

endmodule

// File: hdl/cpfm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_ram - generic single port write, registered read RAM
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module cpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/cpfm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_front - capture pairing and period logging
// Accepts capture transactions, pairs measured captures, computes the period,
// writes the scaled period into the log and hands a job to the queue.
// ----------------------------------------------------------------------------
module cpfm_front #(
    parameter int LOG_DEPTH = cpfm_pkg::LOG_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    cpfm_in_if.sink        capture,
    output logic           push,
    output cpfm_pkg::job_t push_job,
    input  logic           full
);

    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    logic                          awaiting_reg, awaiting_next;
    logic [cpfm_pkg::CAP_W-1:0]    first_reg, first_next;
    logic [CNT_W-1:0]              count_reg, count_next;

    logic                          accept;
    logic                          measured;
    logic [cpfm_pkg::CAP_W-1:0]    diff;
    logic [cpfm_pkg::CAP_W:0]      wrap;
    logic [cpfm_pkg::CAP_W-1:0]    period;
    logic [cpfm_pkg::LOGGED_W-1:0] logged;
    logic                          log_room;
    logic [31:0]                   count_ext;

    assign capture.ready = !full;
    assign accept        = capture.valid && capture.ready;
    assign measured      = accept && capture.on_measured_channel;

    // period of the pair, wrap formula when the second is not greater
    assign diff   = capture.capture_value - first_reg;
    assign wrap   = cpfm_pkg::WRAP_TOP - {1'b0, first_reg} + {1'b0, capture.capture_value};
    assign period = (capture.capture_value > first_reg) ? diff : wrap[cpfm_pkg::CAP_W-1:0];

    // period times 33
    assign logged = ({6'd0, period} << cpfm_pkg::LOG_SHIFT) + {6'd0, period};

    assign log_room  = count_reg < CNT_W'(LOG_DEPTH);
    assign count_ext = 32'(count_reg);

    // job for the divider
    always_comb
    begin
        push_job.period  = period;
        push_job.zero    = (period == '0);
        push_job.written = log_room;
        push_job.slot    = log_room ? count_ext[cpfm_pkg::SLOT_W-1:0] : '0;
        push_job.logged  = logged;
    end

    assign push = measured && awaiting_reg;

    // pairing and log fill state
    always_comb
    begin
        awaiting_next = awaiting_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        if (measured)
        begin
            awaiting_next = !awaiting_reg;
            if (!awaiting_reg)
            begin
                first_next = capture.capture_value;
            end
            else if (log_room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            first_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            first_reg    <= first_next;
            count_reg    <= count_next;
        end
    end

    // period log
    cpfm_ram #(
        .WIDTH (cpfm_pkg::LOGGED_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .clk     (clk),
        .wr_en   (push && log_room),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (logged),
        .rd_addr (count_reg[IDX_W-1:0]),
        .rd_data ()
    );

endmodule

// File: hdl/cpfm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_queue - short job queue between front end and divider
// Small register FIFO so pairing and division can stall independently.
// ----------------------------------------------------------------------------
module cpfm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cpfm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output cpfm_pkg::job_t pop_job
);

    localparam int DEPTH = cpfm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpfm_pkg::job_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign avail   = (count_reg != '0);
    assign pop_job = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/cpfm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfm_divider - frequency computation and result register
// Restoring division of the timer clock by the period, one quotient bit per
// cycle, then the result transaction is held in an output register.
// ----------------------------------------------------------------------------
module cpfm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        avail,
    input  cpfm_pkg::job_t              pop_job,
    output logic                        pop,
    input  logic [cpfm_pkg::FREQ_W-1:0] timer_clock_hz,
    cpfm_out_if.source                  result
);

    localparam int STEP_W = $clog2(cpfm_pkg::FREQ_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    cpfm_pkg::job_t              job_reg;
    logic [cpfm_pkg::FREQ_W-1:0] dq_reg;
    logic [cpfm_pkg::CAP_W-1:0]  rem_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        out_valid_reg;
    cpfm_pkg::job_t              out_job_reg;
    logic [cpfm_pkg::FREQ_W-1:0] out_freq_reg;

    logic [cpfm_pkg::CAP_W:0]    trial;
    logic [cpfm_pkg::CAP_W:0]    trial_diff;
    logic                        q_bit;
    logic                        out_free;

    // one restoring division step
    assign trial      = {rem_reg, dq_reg[cpfm_pkg::FREQ_W-1]};
    assign trial_diff = trial - {1'b0, job_reg.period};
    assign q_bit      = (trial >= {1'b0, job_reg.period});

    assign out_free = !out_valid_reg || result.ready;
    assign pop      = (state_reg == ST_IDLE) && avail;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            dq_reg        <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_job_reg   <= '0;
            out_freq_reg  <= '0;
        end
        else
        begin
            // output drained, unless a new result is loaded this cycle
            if (out_valid_reg && result.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (avail)
                    begin
                        job_reg  <= pop_job;
                        rem_reg  <= '0;
                        step_reg <= '0;
                        if (pop_job.zero)
                        begin
                            dq_reg    <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            dq_reg    <= timer_clock_hz;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    dq_reg   <= {dq_reg[cpfm_pkg::FREQ_W-2:0], q_bit};
                    rem_reg  <= q_bit ? trial_diff[cpfm_pkg::CAP_W-1:0]
                                      : trial[cpfm_pkg::CAP_W-1:0];
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(cpfm_pkg::FREQ_W - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_job_reg   <= job_reg;
                        out_freq_reg  <= dq_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result transaction
    assign result.valid        = out_valid_reg;
    assign result.period_ticks = out_job_reg.period;
    assign result.frequency_hz = out_freq_reg;
    assign result.zero_period  = out_job_reg.zero;
    assign result.log_written  = out_job_reg.written;
    assign result.log_slot     = out_job_reg.slot;
    assign result.logged_value = out_job_reg.logged;

endmodule

// File: tb/sv/capture_pair_frequency_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_pair_frequency_meter_tb - self-checking bench for the frequency meter
// Feeds capture transactions through a bursty driver, stalls the result side
// on changing patterns, and checks every result against a local prediction
// of pairing, wrap period, division, log fill and the timer clock register.
// ----------------------------------------------------------------------------
module capture_pair_frequency_meter_tb;

    import cpfm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 45;
    localparam int PHASE_ITEMS   = 203;
    localparam int LOG_SLOTS     = LOG_DEPTH_DEF;

    localparam logic [APB_ADDR_W-1:0] ADDR_TIMER_CLOCK = APB_ADDR_W'(4 * REG_TIMER_CLOCK);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE       = APB_ADDR_W'(4);

    typedef struct packed {
        logic             onch;
        logic [CAP_W-1:0] value;
    } capture_t;

    typedef struct packed {
        logic [CAP_W-1:0]    period;
        logic [FREQ_W-1:0]   freq;
        logic                zero;
        logic                written;
        logic [SLOT_W-1:0]   slot;
        logic [LOGGED_W-1:0] logged;
    } meas_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cpfm_in_if  cap_bus ();
    cpfm_out_if res_bus ();

    capture_pair_frequency_meter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (cap_bus),
        .result  (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic              pair_open;
    logic [CAP_W-1:0]  first_cap;
    logic [5:0]        log_fill;
    logic [FREQ_W-1:0] timer_hz;

    capture_t capture_backlog[$];
    meas_t    due_measurements[$];

    // driver and receiver control
    bit cap_taken;
    bit hold_feed;
    bit tx_gaps_on;
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_tick;
    int rx_stall_left;

    // run statistics
    int errors;
    int cycle_count;
    int accepted_cnt;
    int ignored_cnt;
    int result_cnt;
    int zero_cnt;
    int full_cnt;
    int clock_settings;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
    endtask

    // next result for one accepted capture transaction
    function automatic void measure_capture(input logic onch, input logic [CAP_W-1:0] cap);
        meas_t       m;
        logic [16:0] wide;
        if (!onch)
        begin
            ignored_cnt++;
            return;
        end
        if (!pair_open)
        begin
            first_cap = cap;
            pair_open = 1'b1;
            return;
        end
        pair_open = 1'b0;
        // second not greater takes the wrap formula as specified
        if (cap > first_cap)
            m.period = cap - first_cap;
        else
        begin
            wide     = 17'h0FFFF - {1'b0, first_cap} + {1'b0, cap};
            m.period = wide[CAP_W-1:0];
        end
        m.zero   = (m.period == '0);
        m.freq   = m.zero ? '0 : timer_hz / {16'd0, m.period};
        m.logged = {6'd0, m.period} * 22'd33;
        if (log_fill < LOG_SLOTS)
        begin
            m.written = 1'b1;
            m.slot    = log_fill[SLOT_W-1:0];
            log_fill++;
        end
        else
        begin
            m.written = 1'b0;
            m.slot    = '0;
            full_cnt++;
        end
        if (m.zero)
            zero_cnt++;
        due_measurements.push_back(m);
    endfunction

    // capture driver, bursts with gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            cap_bus.valid <= 1'b0;
        else if (cap_bus.valid && !cap_taken)
            ;
        else if (gap_left > 0)
        begin
            gap_left--;
            cap_bus.valid <= 1'b0;
        end
        else if (capture_backlog.size() != 0 && !hold_feed)
        begin
            cap_bus.valid               <= 1'b1;
            cap_bus.on_measured_channel <= capture_backlog[0].onch;
            cap_bus.capture_value       <= capture_backlog[0].value;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(24, 1);
                if (tx_gaps_on)
                    gap_left = ($urandom_range(7) == 0) ? $urandom_range(50, 20)
                                                        : $urandom_range(6);
            end
        end
        else
            cap_bus.valid <= 1'b0;
        cap_taken = 1'b0;
    end

    // capture acceptance feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && cap_bus.valid && cap_bus.ready)
        begin
            measure_capture(cap_bus.on_measured_channel, cap_bus.capture_value);
            void'(capture_backlog.pop_front());
            cap_taken = 1'b1;
            accepted_cnt++;
        end
    end

    // result receiver stall pattern
    always @(negedge clk)
    begin : rx_stall
        logic rdy_next;
        rx_tick++;
        case (rx_mode)
            0: rdy_next = 1'b1;
            1: rdy_next = ($urandom_range(3) != 0);
            2: rdy_next = ((rx_tick % 7) < 4);
            default:
            begin
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    rdy_next = 1'b0;
                end
                else
                begin
                    rdy_next = 1'b1;
                    if ($urandom_range(15) == 0)
                        rx_stall_left = $urandom_range(40, 10);
                end
            end
        endcase
        if ((rx_tick % 500) == 0)
            rx_mode = $urandom_range(3);
        res_bus.ready <= rdy_next;
    end

    // result monitor
    always @(posedge clk)
    begin : rx_check
        meas_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            result_cnt++;
            if (due_measurements.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result transaction with none expected: period 0x%0h",
                             res_bus.period_ticks);
            end
            else
            begin
                want = due_measurements.pop_front();
                check_field("period_ticks", 32'(want.period), 32'(res_bus.period_ticks));
                check_field("frequency_hz", want.freq, res_bus.frequency_hz);
                check_field("zero_period", 32'(want.zero), 32'(res_bus.zero_period));
                check_field("log_written", 32'(want.written), 32'(res_bus.log_written));
                check_field("log_slot", 32'(want.slot), 32'(res_bus.log_slot));
                check_field("logged_value", 32'(want.logged), 32'(res_bus.logged_value));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_measurements.size());
            $display("capture_pair_frequency_meter verification failed");
            $finish;
        end
    end

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timer_clock(input logic [FREQ_W-1:0] hz);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, ADDR_TIMER_CLOCK, hz, rd);
        timer_hz = hz;
        clock_settings++;
        apb_xfer(1'b0, ADDR_TIMER_CLOCK, '0, rd);
        check_field("timer_clock_hz readback", timer_hz, rd);
    endtask

    task automatic push_capture(input logic onch, input logic [CAP_W-1:0] value);
        capture_t c;
        c.onch  = onch;
        c.value = value;
        capture_backlog.push_back(c);
    endtask

    function automatic logic [CAP_W-1:0] edge_value();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return CAP_W'($urandom);
        endcase
    endfunction

    // mostly well formed pairs, some other-channel noise and lone captures
    task automatic queue_random_captures(input int n);
        int               made;
        int               pick;
        logic [CAP_W-1:0] a;
        logic [CAP_W-1:0] b;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                push_capture(1'b0, CAP_W'($urandom));
            else if (pick < 13)
            begin
                push_capture(1'b1, edge_value());
                made++;
            end
            else
            begin
                a = edge_value();
                case ($urandom_range(6))
                    0, 1: b = CAP_W'($urandom);
                    2:    b = a + CAP_W'($urandom_range(8, 1));
                    3:    b = a;
                    4:    b = a - CAP_W'($urandom_range(8, 1));
                    5:    b = edge_value();
                    default: b = a ^ CAP_W'(1 << $urandom_range(15));
                endcase
                push_capture(1'b1, a);
                if ($urandom_range(7) == 0)
                    push_capture(1'b0, CAP_W'($urandom));
                push_capture(1'b1, b);
                made += 2;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (capture_backlog.size() != 0 || due_measurements.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one random phase, optionally holding the feed until everything has drained
    task automatic run_phase(input bit gaps, input bit mid_pause);
        @(posedge clk);
        tx_gaps_on = gaps;
        queue_random_captures(PHASE_ITEMS);
        if (mid_pause)
        begin
            do
                @(negedge clk);
            while (capture_backlog.size() > PHASE_ITEMS / 2);
            @(posedge clk);
            hold_feed = 1'b1;
            do
                @(negedge clk);
            while (cap_bus.valid || due_measurements.size() != 0);
            repeat (20) @(negedge clk);
            @(posedge clk);
            hold_feed = 1'b0;
        end
        wait_idle();
    endtask

    // stimulus and final verdict
    initial
    begin : stimulus
        logic [APB_DATA_W-1:0] rd;
        rst_n                       = 1'b0;
        psel                        = 1'b0;
        penable                     = 1'b0;
        pwrite                      = 1'b0;
        paddr                       = '0;
        pwdata                      = '0;
        cap_bus.valid               = 1'b0;
        cap_bus.on_measured_channel = 1'b0;
        cap_bus.capture_value       = '0;
        res_bus.ready               = 1'b0;
        pair_open                   = 1'b0;
        first_cap                   = '0;
        log_fill                    = '0;
        timer_hz                    = TIMER_CLOCK_RST;
        hold_feed                   = 1'b0;
        tx_gaps_on                  = 1'b1;
        burst_left                  = 4;
        gap_left                    = 0;
        rx_mode                     = 0;
        rx_tick                     = 0;
        rx_stall_left               = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register reset value
        apb_xfer(1'b0, ADDR_TIMER_CLOCK, '0, rd);
        check_field("timer_clock_hz after reset", TIMER_CLOCK_RST, rd);

        // directed: other channel, extremes, wrap and zero periods
        push_capture(1'b0, 16'h1234);
        push_capture(1'b1, 16'h0000);
        push_capture(1'b1, 16'hFFFF);
        push_capture(1'b1, 16'hFFFF);
        push_capture(1'b1, 16'hFFFF);
        push_capture(1'b1, 16'hFFFF);
        push_capture(1'b1, 16'h0000);
        push_capture(1'b1, 16'h0000);
        push_capture(1'b1, 16'h0000);
        push_capture(1'b1, 16'h0005);
        push_capture(1'b1, 16'h0006);
        push_capture(1'b1, 16'h0064);
        push_capture(1'b1, 16'h0032);
        push_capture(1'b1, 16'h0100);
        push_capture(1'b0, 16'hFFFF);
        push_capture(1'b1, 16'h0200);
        push_capture(1'b1, 16'h8000);
        push_capture(1'b1, 16'h7FFF);
        push_capture(1'b1, 16'hAAAA);
        push_capture(1'b1, 16'h5555);
        push_capture(1'b1, 16'h5555);
        push_capture(1'b1, 16'hAAAA);
        push_capture(1'b0, 16'h0000);
        wait_idle();

        // random phases across timer clock settings
        set_timer_clock(32'd1);
        run_phase(1'b1, 1'b0);
        set_timer_clock(32'hFFFF_FFFF);
        run_phase(1'b0, 1'b1);
        set_timer_clock($urandom);
        run_phase(1'b1, 1'b0);

        // a write to an unmapped register leaves the timer clock alone
        apb_xfer(1'b1, ADDR_SPARE, $urandom, rd);
        apb_xfer(1'b0, ADDR_TIMER_CLOCK, '0, rd);
        check_field("timer_clock_hz after spare write", timer_hz, rd);
        run_phase(1'b1, 1'b0);

        set_timer_clock(TIMER_CLOCK_RST);
        run_phase(1'b1, 1'b1);
        set_timer_clock($urandom_range(70000, 1));
        run_phase(1'b0, 1'b0);
        set_timer_clock(32'h8000_0000);
        run_phase(1'b1, 1'b0);
        set_timer_clock($urandom);
        run_phase(1'b1, 1'b0);

        if (due_measurements.size() != 0)
        begin
            errors++;
            $display("%0d expected results never arrived", due_measurements.size());
        end

        $display("run covered %0d capture transactions (%0d other channel) and %0d results",
                 accepted_cnt, ignored_cnt, result_cnt);
        $display("with %0d zero periods, %0d after the log filled, %0d timer clock settings",
                 zero_cnt, full_cnt, clock_settings);
        if (errors == 0)
            $display("capture_pair_frequency_meter verification clean");
        else
            $display("capture_pair_frequency_meter verification failed");
        $finish;
    end

endmodule
